@@ rtl/core/tsep_pkg.sv @@
// ----------------------------------------------------------------------------
// tsep_pkg - shared types and constants of the text style escape parser
// Operation and stage codes, escape characters, result and state records.
// ----------------------------------------------------------------------------
package tsep_pkg;

  localparam int unsigned TSEP_QUEUE_DEPTH = 8;
  localparam int unsigned MAX_RESULTS      = 3;
  localparam int unsigned COUNT_W          = 16;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_EOL  = 2'd1,
    OP_EOG  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DOLLAR   = 2'd1,
    ST_DOLLAR_C = 2'd2
  } stage_t;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_STYLE = 1'b1;

  localparam int unsigned FACE_BOLD      = 0;
  localparam int unsigned FACE_ITALIC    = 1;
  localparam int unsigned FACE_UNDERLINE = 2;

  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_BOLD_ON  = 8'h42;
  localparam logic [7:0] CH_BOLD_OFF = 8'h62;
  localparam logic [7:0] CH_ITAL_ON  = 8'h49;
  localparam logic [7:0] CH_ITAL_OFF = 8'h69;
  localparam logic [7:0] CH_UNDL_ON  = 8'h55;
  localparam logic [7:0] CH_UNDL_OFF = 8'h75;
  localparam logic [7:0] CH_COLOUR   = 8'h43;
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h37;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_NUL      = 8'h00;

  typedef struct packed {
    logic               kind;
    logic [7:0]         out_byte;
    logic [COUNT_W-1:0] position;
    logic               bold;
    logic               italic;
    logic               underline;
    logic [2:0]         colour;
    logic               last;
  } result_t;

  typedef struct packed {
    stage_t             stage;
    logic [COUNT_W-1:0] text_count;
    logic [COUNT_W-1:0] escape_position;
    logic [2:0]         face;
    logic [2:0]         colour;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]    count;
    result_t [2:0] res;
  } emit_t;

endpackage

@@ rtl/core/tsep_step.sv @@
// ----------------------------------------------------------------------------
// tsep_step - one parsing step
// Maps the parser state and one input transaction to up to three results
// and the next parser state.
// ----------------------------------------------------------------------------
module tsep_step (
  input  tsep_pkg::parse_state_t state,
  input  tsep_pkg::op_t          op,
  input  logic [7:0]             char_byte,
  output tsep_pkg::parse_state_t state_nxt,
  output tsep_pkg::emit_t        emit
);
  import tsep_pkg::*;

  function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a, logic [1:0] k);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + (COUNT_W+1)'(k);
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

  logic       rec;
  logic       do_flush;
  logic       do_plain;
  logic       do_extra;
  logic [7:0] extra_byte;
  logic [1:0] nt;
  logic [7:0] tb [3];

  always_comb begin
    state_nxt  = state;
    rec        = 1'b0;
    do_flush   = 1'b0;
    do_plain   = 1'b0;
    do_extra   = 1'b0;
    extra_byte = CH_NUL;
    nt         = 2'd0;
    tb[0]      = CH_NUL;
    tb[1]      = CH_NUL;
    tb[2]      = CH_NUL;
    emit       = '0;

    unique case (op)
      OP_CHAR: begin
        unique case (state.stage)
          ST_DOLLAR: begin
            rec = 1'b1;
            case (char_byte)
              CH_BOLD_ON:  state_nxt.face[FACE_BOLD]      = 1'b1;
              CH_BOLD_OFF: state_nxt.face[FACE_BOLD]      = 1'b0;
              CH_ITAL_ON:  state_nxt.face[FACE_ITALIC]    = 1'b1;
              CH_ITAL_OFF: state_nxt.face[FACE_ITALIC]    = 1'b0;
              CH_UNDL_ON:  state_nxt.face[FACE_UNDERLINE] = 1'b1;
              CH_UNDL_OFF: state_nxt.face[FACE_UNDERLINE] = 1'b0;
              default:     rec = 1'b0;
            endcase
            if (rec) begin
              state_nxt.stage = ST_IDLE;
            end else if (char_byte == CH_COLOUR) begin
              state_nxt.stage = ST_DOLLAR_C;
            end else begin
              do_flush = 1'b1;
              do_plain = 1'b1;
            end
          end
          ST_DOLLAR_C: begin
            if (char_byte >= CH_DIGIT_LO && char_byte <= CH_DIGIT_HI) begin
              rec              = 1'b1;
              state_nxt.colour = char_byte[2:0];
              state_nxt.stage  = ST_IDLE;
            end else begin
              do_flush = 1'b1;
              do_plain = 1'b1;
            end
          end
          default: do_plain = 1'b1;
        endcase
      end
      OP_EOL: begin
        do_flush   = 1'b1;
        do_extra   = 1'b1;
        extra_byte = CH_CR;
      end
      OP_EOG: begin
        do_flush         = 1'b1;
        do_extra         = 1'b1;
        extra_byte       = CH_NUL;
        state_nxt.face   = '0;
        state_nxt.colour = '0;
      end
      default: ;
    endcase

    if (do_flush) begin
      unique case (state.stage)
        ST_DOLLAR: begin
          tb[nt] = CH_DOLLAR;
          nt     = nt + 2'd1;
        end
        ST_DOLLAR_C: begin
          tb[nt] = CH_DOLLAR;
          nt     = nt + 2'd1;
          tb[nt] = CH_COLOUR;
          nt     = nt + 2'd1;
        end
        default: ;
      endcase
      state_nxt.stage = ST_IDLE;
    end

    if (do_plain) begin
      if (char_byte == CH_DOLLAR) begin
        state_nxt.stage           = ST_DOLLAR;
        state_nxt.escape_position = sat_add(state.text_count, nt);
      end else begin
        state_nxt.stage = ST_IDLE;
        tb[nt]          = char_byte;
        nt              = nt + 2'd1;
      end
    end

    if (do_extra) begin
      tb[nt] = extra_byte;
      nt     = nt + 2'd1;
    end

    state_nxt.text_count = sat_add(state.text_count, nt);

    if (rec) begin
      emit.count               = 2'd1;
      emit.res[0].kind         = KIND_STYLE;
      emit.res[0].position     = state.escape_position;
      emit.res[0].bold         = state_nxt.face[FACE_BOLD];
      emit.res[0].italic       = state_nxt.face[FACE_ITALIC];
      emit.res[0].underline    = state_nxt.face[FACE_UNDERLINE];
      emit.res[0].colour       = state_nxt.colour;
      emit.res[0].last         = 1'b1;
    end else begin
      emit.count = nt;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        emit.res[k].kind     = KIND_TEXT;
        emit.res[k].out_byte = tb[k];
        emit.res[k].last     = (2'(k) + 2'd1 == nt);
      end
    end
  end

endmodule

@@ rtl/core/tsep_queue.sv @@
// ----------------------------------------------------------------------------
// tsep_queue - result queue
// Takes up to three results per cycle and hands them out one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
module tsep_queue #(
  parameter int unsigned DEPTH = tsep_pkg::TSEP_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               push_n,
  input  tsep_pkg::result_t [2:0]  push_res,
  output logic                     space_ok,
  output logic                     out_valid,
  input  logic                     out_ready,
  output tsep_pkg::result_t        out_res
);
  import tsep_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] wrap(logic [PW-1:0] base, logic [1:0] k);
    logic [PW:0] s;
    s = {1'b0, base} + (PW+1)'(k);
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  result_t       mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign out_valid  = (count_r != '0);
  assign pop        = out_valid && out_ready;
  assign out_res    = mem_r[rd_ptr_r];
  assign space_ok   = (count_r <= CW'(DEPTH - MAX_RESULTS));
  assign wr_ptr_nxt = wrap(wr_ptr_r, push_n);
  assign rd_ptr_nxt = wrap(rd_ptr_r, {1'b0, pop});
  assign count_nxt  = count_r + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_n) begin
        mem_r[wrap(wr_ptr_r, 2'(k))] <= push_res[k];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue count exceeds depth");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |=> out_valid)
    else $error("result queue empty after push");
`endif

endmodule

@@ rtl/core/text_style_escape_parser.sv @@
// ----------------------------------------------------------------------------
// text_style_escape_parser - style escape stripper for a text stream
// Strips $B/$b, $I/$i, $U/$u and $C0..$C7 escapes into style-change records
// and passes all other bytes through as text.
// ----------------------------------------------------------------------------
// Accepts one input transaction per cycle. Each transaction is held in an
// input register, parsed in a single combinational step and yields zero to
// three results, which are written into a result queue (QUEUE_DEPTH entries)
// in that same cycle; the result channel drains one result per cycle while
// out_ready is high. The input register advances whenever the queue has room
// for three results, so input stalls only when the result side falls behind.
// A transaction passes through the input register and then the result queue.
module text_style_escape_parser #(
  parameter int unsigned QUEUE_DEPTH = tsep_pkg::TSEP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_position,
  output logic        out_bold,
  output logic        out_italic,
  output logic        out_underline,
  output logic [2:0]  out_colour,
  output logic        out_last
);
  import tsep_pkg::*;

  logic         st_valid_r;
  op_t          op_r;
  logic [7:0]   byte_r;
  parse_state_t state_r, state_nxt;
  emit_t        emit;
  logic         space_ok;
  logic         fire;
  logic [1:0]   push_n;
  result_t      head;

  assign fire     = st_valid_r && space_ok;
  assign in_ready = !st_valid_r || fire;
  assign push_n   = fire ? emit.count : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_ready) begin
      st_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= op_t'(in_operation);
      byte_r <= in_char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.stage           <= ST_IDLE;
      state_r.text_count      <= '0;
      state_r.escape_position <= '0;
      state_r.face            <= '0;
      state_r.colour          <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  tsep_step u_step (
    .state     (state_r),
    .op        (op_r),
    .char_byte (byte_r),
    .state_nxt (state_nxt),
    .emit      (emit)
  );

  tsep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_res  (emit.res),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (head)
  );

  assign out_kind      = head.kind;
  assign out_byte      = head.out_byte;
  assign out_position  = head.position;
  assign out_bold      = head.bold;
  assign out_italic    = head.italic;
  assign out_underline = head.underline;
  assign out_colour    = head.colour;
  assign out_last      = head.last;

`ifndef NO_ASSERTIONS
  a_marker_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_r == OP_EOL || op_r == OP_EOG) |=> out_valid)
    else $error("line or group marker produced no result");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> state_r.text_count >= $past(state_r.text_count))
    else $error("text position decreased");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid_r && !space_ok |=> st_valid_r && $stable(op_r) && $stable(byte_r))
    else $error("stalled transaction lost");
`endif

endmodule

@@ dv/tb_text_style_escape_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_style_escape_parser - testbench of the text style escape parser
// Drives characters, end-of-line and end-of-group transactions with random
// gaps, predicts the text bytes and style records that each one yields, and
// checks every result in order while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_text_style_escape_parser;
  import tsep_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS   = 120;
  localparam int unsigned PRESSURE_ITEMS = 60;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_CHAR;
  logic [7:0]  in_char_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_position;
  logic        out_bold;
  logic        out_italic;
  logic        out_underline;
  logic [2:0]  out_colour;
  logic        out_last;

  // shadow parser state
  stage_t             stage = ST_IDLE;
  logic [COUNT_W-1:0] text_cnt = '0;
  logic [COUNT_W-1:0] esc_pos = '0;
  logic [2:0]         face = '0;
  logic [2:0]         colour = '0;

  result_t item_results[$];
  result_t parsed_q[$];

  bit hold_req = 1'b0;
  bit no_idle = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_styles = 0;
  int idle_cycles = 0;

  logic [7:0] face_letters[6] = '{CH_BOLD_ON, CH_BOLD_OFF, CH_ITAL_ON,
                                  CH_ITAL_OFF, CH_UNDL_ON, CH_UNDL_OFF};

  text_style_escape_parser uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_position (out_position),
    .out_bold     (out_bold),
    .out_italic   (out_italic),
    .out_underline(out_underline),
    .out_colour   (out_colour),
    .out_last     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void emit_text(logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_TEXT;
    r.out_byte = b;
    item_results = {item_results, r};
    if (text_cnt != '1) text_cnt++;
  endfunction

  function automatic void emit_style();
    result_t r;
    r = '0;
    r.kind = KIND_STYLE;
    r.position = esc_pos;
    r.bold = face[FACE_BOLD];
    r.italic = face[FACE_ITALIC];
    r.underline = face[FACE_UNDERLINE];
    r.colour = colour;
    item_results = {item_results, r};
  endfunction

  function automatic void flush_escape();
    if (stage == ST_DOLLAR) begin
      emit_text(CH_DOLLAR);
    end else if (stage == ST_DOLLAR_C) begin
      emit_text(CH_DOLLAR);
      emit_text(CH_COLOUR);
    end
    stage = ST_IDLE;
  endfunction

  function automatic void idle_byte(logic [7:0] b);
    if (b == CH_DOLLAR) begin
      stage = ST_DOLLAR;
      esc_pos = text_cnt;
    end else begin
      emit_text(b);
    end
  endfunction

  function automatic void parse_item(logic [1:0] op, logic [7:0] b);
    bit rec;
    item_results.delete();
    case (op)
      OP_CHAR: begin
        case (stage)
          ST_DOLLAR: begin
            rec = 1'b1;
            case (b)
              CH_BOLD_ON:  face[FACE_BOLD] = 1'b1;
              CH_BOLD_OFF: face[FACE_BOLD] = 1'b0;
              CH_ITAL_ON:  face[FACE_ITALIC] = 1'b1;
              CH_ITAL_OFF: face[FACE_ITALIC] = 1'b0;
              CH_UNDL_ON:  face[FACE_UNDERLINE] = 1'b1;
              CH_UNDL_OFF: face[FACE_UNDERLINE] = 1'b0;
              default:     rec = 1'b0;
            endcase
            if (rec) begin
              stage = ST_IDLE;
              emit_style();
            end else if (b == CH_COLOUR) begin
              stage = ST_DOLLAR_C;
            end else begin
              flush_escape();
              idle_byte(b);
            end
          end
          ST_DOLLAR_C: begin
            if (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) begin
              colour = 3'(b - CH_DIGIT_LO);
              stage = ST_IDLE;
              emit_style();
            end else begin
              flush_escape();
              idle_byte(b);
            end
          end
          default: idle_byte(b);
        endcase
      end
      OP_EOL: begin
        flush_escape();
        emit_text(CH_CR);
      end
      OP_EOG: begin
        flush_escape();
        emit_text(CH_NUL);
        face = '0;
        colour = '0;
      end
      default: ;
    endcase
    if (item_results.size() > 0) item_results[item_results.size()-1].last = 1'b1;
    parsed_q = {parsed_q, item_results};
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(logic [1:0] op, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_char_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_item(op, b);
    if (op != OP_NOP) n_items++;
  endtask

  task automatic send_char(logic [7:0] b);
    send_item(OP_CHAR, b);
  endtask

  task automatic send_escape(logic [7:0] letter);
    send_char(CH_DOLLAR);
    send_char(letter);
  endtask

  task automatic send_colour(logic [7:0] digit);
    send_char(CH_DOLLAR);
    send_char(CH_COLOUR);
    send_char(digit);
  endtask

  task automatic send_random_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      send_char(8'($urandom_range(0, 255)));
    end else if (r < 62) begin
      send_escape(face_letters[$urandom_range(0, 5)]);
    end else if (r < 77) begin
      send_colour(CH_DIGIT_LO + 8'($urandom_range(0, 7)));
    end else if (r < 82) begin
      send_escape(8'($urandom_range(0, 255)));
    end else if (r < 87) begin
      send_colour(8'($urandom_range(0, 255)));
    end else if (r < 91) begin
      send_char(CH_DOLLAR);
    end else if (r < 95) begin
      send_item(OP_EOL, 8'($urandom_range(0, 255)));
    end else if (r < 99) begin
      send_item(OP_EOG, 8'($urandom_range(0, 255)));
    end else begin
      send_item(OP_NOP, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_DOLLAR);
    send_escape(CH_BOLD_ON);
    send_escape(CH_ITAL_ON);
    send_escape(CH_UNDL_ON);
    send_escape(CH_BOLD_OFF);
    send_colour(CH_DIGIT_LO);
    send_colour(8'h38);
    send_colour(CH_DIGIT_HI);
    send_char(CH_DOLLAR);
    send_char(CH_COLOUR);
    send_item(OP_EOL, 8'hA5);
    send_char(CH_DOLLAR);
    send_item(OP_EOG, 8'h5A);
    send_item(OP_NOP, 8'hFF);
  endtask

  task automatic test_random_stream();
    int start;
    start = n_items;
    while (n_items - start < RANDOM_ITEMS) send_random_token();
  endtask

  task automatic test_backpressure();
    int start;
    no_idle = 1'b1;
    hold_req = 1'b1;
    start = n_items;
    while (n_items - start < PRESSURE_ITEMS) send_random_token();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_stream();
    test_backpressure();
    test_random_stream();
    in_valid <= 1'b0;
    while (parsed_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions; checked %0d results, %0d of them style records.",
             n_items, n_results, n_styles);
    $display("Covered face and colour escapes, broken escapes, line and group ends,");
    $display("and a long output hold-off that stalls the input.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] expv, logic [15:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (parsed_q.size() == 0) begin
        $error("result with none expected: kind %0d byte %0d", out_kind, out_byte);
        errors++;
      end else begin
        want = parsed_q.pop_front();
        if (want.kind == KIND_STYLE) n_styles++;
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
        check_field("position", want.position, out_position);
        check_field("bold", 16'(want.bold), 16'(out_bold));
        check_field("italic", 16'(want.italic), 16'(out_italic));
        check_field("underline", 16'(want.underline), 16'(out_underline));
        check_field("colour", 16'(want.colour), 16'(out_colour));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
